FILE: design/bas_pkg.sv
// shared types, constants and codes of the slot table allocator
package bas_pkg;

  localparam int unsigned SLOTS       = 64;
  // block size and minimum alignment must be powers of two
  localparam int unsigned BLOCK_BYTES = 16;
  localparam int unsigned MIN_ALIGN   = 16;

  localparam int unsigned ADDR_W  = 32;
  localparam int unsigned LIVE_W  = 7;
  localparam int unsigned STS_W   = 3;
  localparam int unsigned TYPE_W  = 2;
  localparam int unsigned CFG_W   = 1;
  localparam int unsigned IDX_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  // rounded length of size + alignment + 4 fits in 34 bits
  localparam int unsigned RND_W   = ADDR_W + 2;

  localparam logic [TYPE_W-1:0] REQ_ALLOC   = 2'd0;
  localparam logic [TYPE_W-1:0] REQ_ALIGNED = 2'd1;
  localparam logic [TYPE_W-1:0] REQ_FREE    = 2'd2;

  localparam logic [CFG_W-1:0] CFG_HEAP_BASE  = 1'd0;
  localparam logic [CFG_W-1:0] CFG_HEAP_LIMIT = 1'd1;

  typedef enum logic [STS_W-1:0] {
    ST_OK      = 3'd0,
    ST_ZERO    = 3'd1,
    ST_SPACE   = 3'd2,
    ST_SLOT    = 3'd3,
    ST_UNKNOWN = 3'd4,
    ST_NULL    = 3'd5
  } status_e;

  typedef struct packed {
    logic [ADDR_W-1:0] base;
    logic [ADDR_W-1:0] length;
    logic              aligned;
  } slot_entry_t;

  typedef struct packed {
    logic             set_en;
    logic             clr_en;
    logic [IDX_W-1:0] idx;
    slot_entry_t      entry;
  } slot_cmd_t;

endpackage

FILE: design/bas_if.sv
// request and response channel interfaces of the slot table allocator
interface bas_req_if;
  logic                          valid;
  logic                          ready;
  logic [bas_pkg::TYPE_W-1:0]    req_type;
  logic [bas_pkg::ADDR_W-1:0]    request_size;
  logic [bas_pkg::ADDR_W-1:0]    alignment;
  logic [bas_pkg::ADDR_W-1:0]    address;

  modport source (output valid, req_type, request_size, alignment, address, input ready);
  modport sink   (input valid, req_type, request_size, alignment, address, output ready);
endinterface

interface bas_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [bas_pkg::STS_W-1:0]     status;
  logic [bas_pkg::ADDR_W-1:0]    result_address;
  logic [bas_pkg::LIVE_W-1:0]    live_allocations;
  logic [bas_pkg::ADDR_W-1:0]    allocated_bytes;

  modport source (output valid, status, result_address, live_allocations, allocated_bytes,
                  input ready);
  modport sink   (input valid, status, result_address, live_allocations, allocated_bytes,
                  output ready);
endinterface

FILE: design/bas_slot_store.sv
// slot table storage: entry memory with registered read, in-use bits in flops
module bas_slot_store (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  bas_pkg::slot_cmd_t                   cmd_i,
  input  logic [bas_pkg::IDX_W-1:0]            rd_idx_i,
  output bas_pkg::slot_entry_t                 rd_entry_o,
  output logic [bas_pkg::SLOTS-1:0]            in_use_o
);
  import bas_pkg::*;

  slot_entry_t             mem_q [SLOTS];
  slot_entry_t             rd_q;
  logic [SLOTS-1:0]        in_use_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.set_en) begin
      mem_q[cmd_i.idx] <= cmd_i.entry;
    end
    rd_q <= mem_q[rd_idx_i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_use_q <= '0;
    end else if (cmd_i.set_en) begin
      in_use_q[cmd_i.idx] <= 1'b1;
    end else if (cmd_i.clr_en) begin
      in_use_q[cmd_i.idx] <= 1'b0;
    end
  end

  assign rd_entry_o = rd_q;
  assign in_use_o   = in_use_q;

endmodule

FILE: design/bump_allocator_slot_table.sv
// top level of the bump allocator with its slot table
//
//  channel  dir  handshake     payload
//  req      in   valid/ready   req_type, request_size, alignment, address
//  rsp      out  valid/ready   status, result_address, live_allocations, allocated_bytes
//  cfg      in   cfg_we_i      cfg_idx_i, cfg_wdata_i (heap_base, heap_limit)
//
// one request at a time. allocate: prepare, space check and, if it passes, a walk over the
// in-use bits to the first free slot (or over all of them when none is free), then the
// finish step. free: two in-order passes through the entry memory on its single read port.
// reset clears the in-use bits at once, no clearing pass. the result sits in an output
// register; a new request is taken while it waits, and the next result holds in the finish
// step until the register is free
module bump_allocator_slot_table (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [bas_pkg::CFG_W-1:0]     cfg_idx_i,
  input  logic [bas_pkg::ADDR_W-1:0]    cfg_wdata_i,
  bas_req_if.sink                       req,
  bas_rsp_if.source                     rsp
);
  import bas_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_PREP   = 3'd1;
  localparam logic [2:0] S_SPACE  = 3'd2;
  localparam logic [2:0] S_FIND   = 3'd3;
  localparam logic [2:0] S_SCAN1  = 3'd4;
  localparam logic [2:0] S_SCAN2  = 3'd5;
  localparam logic [2:0] S_FINISH = 3'd6;

  localparam logic [IDX_W-1:0]  LAST_IDX = IDX_W'(SLOTS - 1);
  localparam logic [RND_W-1:0]  BLK_MASK = RND_W'(BLOCK_BYTES - 1);
  localparam logic [ADDR_W-1:0] MIN_AL   = ADDR_W'(MIN_ALIGN);

  logic [2:0]         state_q, state_d;
  logic [TYPE_W-1:0]  typ_q, typ_d;
  logic [ADDR_W-1:0]  size_q, size_d;
  logic [ADDR_W-1:0]  align_q, align_d;
  logic [ADDR_W-1:0]  addr_q, addr_d;
  logic [RND_W-1:0]   rnd_q, rnd_d;
  logic [ADDR_W-1:0]  cand_q, cand_d;
  logic [ADDR_W-1:0]  raw_q, raw_d;
  logic [IDX_W-1:0]   idx_q, idx_d;
  logic [IDX_W-1:0]   chk_idx_q, chk_idx_d;
  logic               chk_vld_q, chk_vld_d;
  status_e            sts_q, sts_d;
  logic [ADDR_W-1:0]  res_q, res_d;

  logic [ADDR_W-1:0]  bump_q, bump_d;
  logic [ADDR_W-1:0]  limit_q, limit_d;
  logic [LIVE_W-1:0]  live_q, live_d;
  logic [ADDR_W-1:0]  tot_q, tot_d;

  logic               out_vld_q;
  status_e            out_sts_q;
  logic [ADDR_W-1:0]  out_res_q;
  logic [LIVE_W-1:0]  out_live_q;
  logic [ADDR_W-1:0]  out_tot_q;
  logic               out_load;

  slot_cmd_t          cmd;
  slot_entry_t        rd_entry;
  logic [SLOTS-1:0]   in_use;

  logic [RND_W-1:0]   total;
  logic [RND_W-1:0]   total_pad;
  logic [ADDR_W:0]    space_sum;
  logic [ADDR_W:0]    space_end;
  logic [ADDR_W-1:0]  al_mask;
  logic               chk_used;
  logic               hit_exact;
  logic               hit_inside;

  bas_slot_store u_store (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .rd_idx_i   (idx_q),
    .rd_entry_o (rd_entry),
    .in_use_o   (in_use)
  );

  // request length, and that length padded for rounding up to whole blocks
  always_comb begin
    if (typ_q == REQ_ALIGNED) begin
      total = RND_W'(size_q) + RND_W'(align_q) + RND_W'(4);
    end else begin
      total = RND_W'(size_q);
    end
    total_pad = total + BLK_MASK;
  end

  assign space_sum  = (ADDR_W + 1)'(bump_q) + (ADDR_W + 1)'(rnd_q);
  assign al_mask    = align_q - ADDR_W'(1);
  assign chk_used   = chk_vld_q && in_use[chk_idx_q];
  assign hit_exact  = rd_entry.base == addr_q;
  assign space_end  = (ADDR_W + 1)'(rd_entry.base) + (ADDR_W + 1)'(rd_entry.length);
  assign hit_inside = rd_entry.aligned && (addr_q >= rd_entry.base) &&
                      ((ADDR_W + 1)'(addr_q) < space_end);

  always_comb begin
    state_d   = state_q;
    typ_d     = typ_q;
    size_d    = size_q;
    align_d   = align_q;
    addr_d    = addr_q;
    rnd_d     = rnd_q;
    cand_d    = cand_q;
    raw_d     = raw_q;
    idx_d     = idx_q;
    chk_idx_d = chk_idx_q;
    chk_vld_d = chk_vld_q;
    sts_d     = sts_q;
    res_d     = res_q;
    bump_d    = bump_q;
    limit_d   = limit_q;
    live_d    = live_q;
    tot_d     = tot_q;
    out_load  = 1'b0;
    cmd       = '0;

    case (state_q)
      S_IDLE: begin
        if (req.valid) begin
          typ_d     = req.req_type;
          size_d    = req.request_size;
          align_d   = (req.alignment < MIN_AL) ? MIN_AL : req.alignment;
          addr_d    = req.address;
          res_d     = '0;
          sts_d     = ST_OK;
          idx_d     = '0;
          chk_vld_d = 1'b0;
          state_d   = S_PREP;
        end
      end
      S_PREP: begin
        rnd_d = total_pad & ~BLK_MASK;
        case (typ_q)
          REQ_ALLOC, REQ_ALIGNED: begin
            state_d = S_SPACE;
          end
          REQ_FREE: begin
            if (addr_q == '0) begin
              sts_d   = ST_NULL;
              state_d = S_FINISH;
            end else begin
              state_d = S_SCAN1;
            end
          end
          default: begin
            state_d = S_FINISH;
          end
        endcase
      end
      S_SPACE: begin
        cand_d = (typ_q == REQ_ALIGNED) ? ((bump_q + al_mask) & ~al_mask) : bump_q;
        if (typ_q == REQ_ALLOC && size_q == '0) begin
          sts_d   = ST_ZERO;
          state_d = S_FINISH;
        end else if (space_sum > (ADDR_W + 1)'(limit_q) || rnd_q[RND_W-1:ADDR_W] != '0) begin
          sts_d   = ST_SPACE;
          state_d = S_FINISH;
        end else begin
          state_d = S_FIND;
        end
      end
      S_FIND: begin
        if (!in_use[idx_q]) begin
          cmd.set_en        = 1'b1;
          cmd.idx           = idx_q;
          cmd.entry.base    = bump_q;
          cmd.entry.length  = rnd_q[ADDR_W-1:0];
          cmd.entry.aligned = (typ_q == REQ_ALIGNED);
          bump_d  = bump_q + rnd_q[ADDR_W-1:0];
          live_d  = live_q + LIVE_W'(1);
          tot_d   = tot_q + rnd_q[ADDR_W-1:0];
          res_d   = cand_q;
          state_d = S_FINISH;
        end else if (idx_q == LAST_IDX) begin
          sts_d   = ST_SLOT;
          state_d = S_FINISH;
        end else begin
          idx_d = idx_q + IDX_W'(1);
        end
      end
      S_SCAN1: begin
        // read issued at idx_q, checked in the cycle after at chk_idx_q
        chk_idx_d = idx_q;
        chk_vld_d = 1'b1;
        idx_d     = (idx_q == LAST_IDX) ? idx_q : idx_q + IDX_W'(1);
        if (chk_used && (hit_exact || hit_inside)) begin
          raw_d     = hit_exact ? addr_q : rd_entry.base;
          idx_d     = '0;
          chk_vld_d = 1'b0;
          state_d   = S_SCAN2;
        end else if (chk_vld_q && chk_idx_q == LAST_IDX) begin
          sts_d   = ST_UNKNOWN;
          state_d = S_FINISH;
        end
      end
      S_SCAN2: begin
        chk_idx_d = idx_q;
        chk_vld_d = 1'b1;
        idx_d     = (idx_q == LAST_IDX) ? idx_q : idx_q + IDX_W'(1);
        if (chk_used && rd_entry.base == raw_q) begin
          cmd.clr_en = 1'b1;
          cmd.idx    = chk_idx_q;
          live_d     = live_q - LIVE_W'(1);
          tot_d      = tot_q - rd_entry.length;
          state_d    = S_FINISH;
        end else if (chk_vld_q && chk_idx_q == LAST_IDX) begin
          sts_d   = ST_UNKNOWN;
          state_d = S_FINISH;
        end
      end
      S_FINISH: begin
        if (!out_vld_q || rsp.ready) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_HEAP_BASE:  bump_d  = cfg_wdata_i;
        CFG_HEAP_LIMIT: limit_d = cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      chk_vld_q <= 1'b0;
      bump_q    <= '0;
      limit_q   <= '0;
      live_q    <= '0;
      tot_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      chk_vld_q <= chk_vld_d;
      bump_q    <= bump_d;
      limit_q   <= limit_d;
      live_q    <= live_d;
      tot_q     <= tot_d;
      if (out_load) begin
        out_vld_q <= 1'b1;
      end else if (rsp.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    typ_q     <= typ_d;
    size_q    <= size_d;
    align_q   <= align_d;
    addr_q    <= addr_d;
    rnd_q     <= rnd_d;
    cand_q    <= cand_d;
    raw_q     <= raw_d;
    idx_q     <= idx_d;
    chk_idx_q <= chk_idx_d;
    sts_q     <= sts_d;
    res_q     <= res_d;
    if (out_load) begin
      out_sts_q  <= sts_q;
      out_res_q  <= res_q;
      out_live_q <= live_q;
      out_tot_q  <= tot_q;
    end
  end

  assign req.ready            = (state_q == S_IDLE);
  assign rsp.valid            = out_vld_q;
  assign rsp.status           = out_sts_q;
  assign rsp.result_address   = out_res_q;
  assign rsp.live_allocations = out_live_q;
  assign rsp.allocated_bytes  = out_tot_q;

endmodule

FILE: dv/bump_allocator_slot_table_test.sv
// self-checking testbench for the bump allocator with its slot table
module bump_allocator_slot_table_test;
  timeunit 1ns;
  timeprecision 1ps;

  import bas_pkg::*;

  localparam logic [TYPE_W-1:0] REQ_UNUSED = 2'd3;
  localparam int unsigned STALL_LIMIT = 3000;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned DRAIN_CYCLES = 150;
  localparam int unsigned PHASES = 9;
  localparam int unsigned PHASE_REQUESTS = 142;

  typedef struct {
    logic [TYPE_W-1:0] kind;
    logic [ADDR_W-1:0] size;
    logic [ADDR_W-1:0] align;
    logic [ADDR_W-1:0] addr;
  } request_t;

  typedef struct {
    logic [STS_W-1:0]  status;
    logic [ADDR_W-1:0] addr;
    logic [LIVE_W-1:0] live;
    logic [ADDR_W-1:0] bytes;
  } response_t;

  class slot_table_scoreboard;
    bit [ADDR_W-1:0] heap_base;
    bit [ADDR_W-1:0] heap_limit;
    bit [ADDR_W-1:0] bump_ptr;
    bit [ADDR_W-1:0] bytes_live;
    bit [LIVE_W-1:0] live;
    bit              used        [SLOTS];
    bit [ADDR_W-1:0] blk_base    [SLOTS];
    bit [ADDR_W-1:0] blk_len     [SLOTS];
    bit              blk_aligned [SLOTS];
    response_t       expected_responses [$];
    int              mismatches;

    function void write_register(logic [CFG_W-1:0] idx, logic [ADDR_W-1:0] data);
      if (idx == CFG_HEAP_BASE) begin
        heap_base = data;
        bump_ptr  = data;
      end else begin
        heap_limit = data;
      end
    endfunction

    function status_e take_block(bit [63:0] total, bit zero_check, output int slot);
      bit [63:0] rounded;
      int i;
      slot = -1;
      if (zero_check && total == 0) return ST_ZERO;
      rounded = (total + BLOCK_BYTES - 1) / BLOCK_BYTES * BLOCK_BYTES;
      // space check is done without wrapping
      if ({32'd0, bump_ptr} + rounded > {32'd0, heap_limit}) return ST_SPACE;
      for (i = 0; i < SLOTS; i++)
        if (!used[i] && slot < 0) slot = i;
      if (slot < 0) return ST_SLOT;
      used[slot]        = 1'b1;
      blk_base[slot]    = bump_ptr;
      blk_len[slot]     = rounded[ADDR_W-1:0];
      blk_aligned[slot] = 1'b0;
      bump_ptr   += rounded[ADDR_W-1:0];
      bytes_live += rounded[ADDR_W-1:0];
      live++;
      return ST_OK;
    endfunction

    function status_e release_block(bit [ADDR_W-1:0] addr);
      bit [ADDR_W-1:0] raw;
      bit hit;
      int i;
      if (addr == 0) return ST_NULL;
      raw = addr;
      hit = 1'b0;
      // exact base, or any address inside an aligned block, names the base to free
      for (i = 0; i < SLOTS; i++) begin
        if (used[i] && !hit) begin
          if (blk_base[i] == addr) begin
            hit = 1'b1;
          end else if (blk_aligned[i] && addr >= blk_base[i] &&
                       {32'd0, addr} < {32'd0, blk_base[i]} + {32'd0, blk_len[i]}) begin
            raw = blk_base[i];
            hit = 1'b1;
          end
        end
      end
      for (i = 0; i < SLOTS; i++) begin
        if (used[i] && blk_base[i] == raw) begin
          used[i] = 1'b0;
          live--;
          bytes_live -= blk_len[i];
          return ST_OK;
        end
      end
      return ST_UNKNOWN;
    endfunction

    function void note_request(request_t r);
      response_t exp;
      bit [ADDR_W-1:0] a;
      int slot;
      exp.status = ST_OK;
      exp.addr   = '0;
      case (r.kind)
        REQ_ALLOC: begin
          exp.status = take_block({32'd0, r.size}, 1'b1, slot);
          if (exp.status == ST_OK) exp.addr = blk_base[slot];
        end
        REQ_ALIGNED: begin
          a = (r.align < MIN_ALIGN) ? MIN_ALIGN : r.align;
          exp.status = take_block({32'd0, r.size} + {32'd0, a} + 64'd4, 1'b0, slot);
          if (exp.status == ST_OK) begin
            blk_aligned[slot] = 1'b1;
            exp.addr = (blk_base[slot] + (a - 1)) & ~(a - 1);
          end
        end
        REQ_FREE: exp.status = release_block(r.addr);
        default: ;
      endcase
      exp.live  = live;
      exp.bytes = bytes_live;
      expected_responses.push_back(exp);
    endfunction

    task report_mismatch(string what);
      if (mismatches < 100) $display("[%0t] mismatch: %s", $realtime, what);
      mismatches++;
    endtask

    task check_response(response_t got);
      response_t exp;
      if (expected_responses.size() == 0) begin
        report_mismatch($sformatf("response with nothing expected, status %0d addr %h",
                                  got.status, got.addr));
        return;
      end
      exp = expected_responses.pop_front();
      if (got.status !== exp.status)
        report_mismatch($sformatf("status %0d, expected %0d", got.status, exp.status));
      if (got.addr !== exp.addr)
        report_mismatch($sformatf("result_address %h, expected %h", got.addr, exp.addr));
      if (got.live !== exp.live)
        report_mismatch($sformatf("live_allocations %0d, expected %0d", got.live, exp.live));
      if (got.bytes !== exp.bytes)
        report_mismatch($sformatf("allocated_bytes %h, expected %h", got.bytes, exp.bytes));
    endtask
  endclass

  logic              clk;
  logic              rst_n;
  logic              cfg_we;
  logic [CFG_W-1:0]  cfg_idx;
  logic [ADDR_W-1:0] cfg_wdata;

  bas_req_if req_bus ();
  bas_rsp_if rsp_bus ();

  slot_table_scoreboard alloc_sb = new;

  int        send_idle_pct;
  int        recv_idle_pct;
  bit        hold_off_request;
  int        hold_left;
  int        stall_cycles;
  response_t rsp_seen;

  bump_allocator_slot_table i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .req         (req_bus),
    .rsp         (rsp_bus)
  );

  always #6 clk = ~clk;

  // response side: check, then decide ready for the next edge
  always @(posedge clk) begin
    if (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
      rsp_seen.status = rsp_bus.status;
      rsp_seen.addr   = rsp_bus.result_address;
      rsp_seen.live   = rsp_bus.live_allocations;
      rsp_seen.bytes  = rsp_bus.allocated_bytes;
      alloc_sb.check_response(rsp_seen);
    end
    if (hold_off_request) begin
      hold_left = HOLD_CYCLES;
      hold_off_request = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      rsp_bus.ready <= 1'b0;
    end else begin
      rsp_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (req_bus.valid === 1'b1 && req_bus.ready === 1'b1) ||
        (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("bump_allocator_slot_table test failed");
        $finish;
      end
    end
  end

  // entered just after a rising edge; returns just after the edge that took the request
  task automatic offer_request(input request_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      req_bus.valid <= 1'b0;
      @(posedge clk);
    end
    req_bus.valid        <= 1'b1;
    req_bus.req_type     <= r.kind;
    req_bus.request_size <= r.size;
    req_bus.alignment    <= r.align;
    req_bus.address      <= r.addr;
    do @(posedge clk); while (req_bus.ready !== 1'b1);
    alloc_sb.note_request(r);
  endtask

  task automatic issue(input logic [TYPE_W-1:0] kind, input logic [ADDR_W-1:0] size,
                       input logic [ADDR_W-1:0] align, input logic [ADDR_W-1:0] addr);
    request_t r;
    r.kind  = kind;
    r.size  = size;
    r.align = align;
    r.addr  = addr;
    offer_request(r);
  endtask

  task automatic wait_drained();
    while (alloc_sb.expected_responses.size() != 0) @(posedge clk);
  endtask

  task automatic configure_heap(input logic [ADDR_W-1:0] base, input logic [ADDR_W-1:0] limit);
    cfg_we    <= 1'b1;
    cfg_idx   <= CFG_HEAP_BASE;
    cfg_wdata <= base;
    @(posedge clk);
    alloc_sb.write_register(CFG_HEAP_BASE, base);
    cfg_idx   <= CFG_HEAP_LIMIT;
    cfg_wdata <= limit;
    @(posedge clk);
    alloc_sb.write_register(CFG_HEAP_LIMIT, limit);
    cfg_we <= 1'b0;
  endtask

  function automatic int pick_slot(bit only_aligned);
    int cands[$];
    for (int i = 0; i < SLOTS; i++)
      if (alloc_sb.used[i] && (!only_aligned || alloc_sb.blk_aligned[i])) cands.push_back(i);
    if (cands.size() == 0) return -1;
    return cands[$urandom_range(cands.size() - 1)];
  endfunction

  function automatic request_t make_request(int free_pct);
    request_t r;
    int roll;
    int s;
    int pick;
    r.kind  = REQ_ALLOC;
    r.size  = $urandom;
    r.align = $urandom;
    r.addr  = $urandom;
    roll = $urandom_range(99);
    if (roll < free_pct) begin
      r.kind = REQ_FREE;
      s = $urandom_range(9);
      pick = pick_slot(s == 5 || s == 6);
      if (s == 7) r.addr = '0;
      else if (s == 8 || pick < 0) r.addr = $urandom;
      else if (s == 5 || s == 6)
        r.addr = alloc_sb.blk_base[pick] + $urandom_range(alloc_sb.blk_len[pick] - 1);
      else if (s == 9) r.addr = alloc_sb.blk_base[pick] + $urandom_range(1, 15);
      else r.addr = alloc_sb.blk_base[pick];
    end else if (roll < free_pct + 4) begin
      r.kind = REQ_UNUSED;
    end else begin
      r.kind = $urandom_range(1) ? REQ_ALIGNED : REQ_ALLOC;
      roll = $urandom_range(99);
      if (roll < 3) r.size = '0;
      else if (roll < 8) r.size = $urandom;
      else if (roll < 12) r.size = $urandom_range(4096);
      else r.size = $urandom_range(1, 256);
      if (r.kind == REQ_ALIGNED) begin
        roll = $urandom_range(99);
        if (roll < 5) r.align = 32'h8000_0000;
        else if (roll < 10) r.align = $urandom;
        else if (roll < 18) r.align = $urandom_range(0, 300);
        else r.align = 32'd1 << $urandom_range(0, 8);
      end
    end
    return r;
  endfunction

  task automatic run_directed();
    // heap_limit is zero out of reset, so nothing fits yet
    issue(REQ_ALLOC,   32'd1, 32'd0, 32'd0);
    issue(REQ_ALLOC,   32'd0, 32'd0, 32'd0);
    issue(REQ_ALIGNED, 32'd0, 32'd0, 32'd0);
    issue(REQ_FREE,    32'd0, 32'd0, 32'd0);
    issue(REQ_FREE,    32'd0, 32'd0, 32'hFFFF_FFFF);
    issue(REQ_UNUSED,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    req_bus.valid <= 1'b0;
    wait_drained();
    configure_heap(32'h0000_1000, 32'h0000_10C0);
    issue(REQ_ALLOC,   32'd1, 32'd0, 32'd0);
    issue(REQ_ALLOC,   32'hFFFF_FFFF, 32'd0, 32'd0);
    issue(REQ_ALIGNED, 32'd0, 32'd0, 32'd0);
    issue(REQ_ALIGNED, 32'd10, 32'd64, 32'd0);
    // alignment that is not a power of two
    issue(REQ_ALIGNED, 32'd8, 32'd24, 32'd0);
    issue(REQ_ALIGNED, 32'hFFFF_FFFF, 32'h8000_0000, 32'd0);
    // inside an aligned block, exact base, inside the plain block just freed, already freed
    issue(REQ_FREE,    32'd0, 32'd0, 32'h0000_1050);
    issue(REQ_FREE,    32'd0, 32'd0, 32'h0000_1000);
    issue(REQ_FREE,    32'd0, 32'd0, 32'h0000_1008);
    issue(REQ_FREE,    32'd0, 32'd0, 32'h0000_1050);
    // first one ends exactly at heap_limit, the next does not fit
    issue(REQ_ALLOC,   32'd16, 32'd0, 32'd0);
    issue(REQ_ALLOC,   32'd1, 32'd0, 32'd0);
    issue(REQ_FREE,    32'd0, 32'd0, 32'h0000_1010);
    req_bus.valid <= 1'b0;
  endtask

  task automatic run_phase(input int ph);
    logic [ADDR_W-1:0] base;
    logic [ADDR_W-1:0] limit;
    logic [ADDR_W-1:0] span;
    int free_pct;
    int counted;
    bit held;
    request_t r;
    counted = 0;
    held = 1'b0;
    span = $urandom_range(32'h400, 32'h4000);
    case (ph)
      0: begin base = 32'h0000_1000; limit = 32'h0000_9000; free_pct = 35; end
      1: begin base = 32'hFFFF_8000; limit = 32'hFFFF_FFFF; free_pct = 30; end
      2: begin base = 32'h0000_0000; limit = 32'hFFFF_FFFF; free_pct = 10; end
      3: begin
        base = $urandom;
        limit = (base > 32'hFFFF_FFFF - span) ? 32'hFFFF_FFFF : base + span;
        free_pct = 35;
      end
      4: begin base = 32'hFFFF_FFFF; limit = 32'h0000_0000; free_pct = 50; end
      5: begin base = 32'h1234_5670; limit = 32'h1234_5E70; free_pct = 40; end
      6: begin base = $urandom; limit = $urandom; free_pct = 30; end
      7: begin base = 32'h8000_0000; limit = 32'h8010_0000; free_pct = 20; end
      default: begin base = 32'h0000_0010; limit = 32'h4000_0000; free_pct = 35; end
    endcase
    send_idle_pct = (ph < 3) ? 22 : (ph < 6) ? 82 : 0;
    recv_idle_pct = (ph < 3) ? 82 : (ph < 6) ? 22 : 0;
    wait_drained();
    configure_heap(base, limit);
    while (counted < PHASE_REQUESTS) begin
      // long receiver hold-off while requests keep coming
      if (counted == 30 && ph % 2 == 1 && !held) begin
        hold_off_request = 1'b1;
        held = 1'b1;
      end
      r = make_request(free_pct);
      offer_request(r);
      if (r.kind != REQ_UNUSED) counted++;
    end
    req_bus.valid <= 1'b0;
  endtask

  initial begin
    clk                  = 1'b0;
    rst_n                = 1'b0;
    cfg_we               = 1'b0;
    cfg_idx              = '0;
    cfg_wdata            = '0;
    req_bus.valid        = 1'b0;
    req_bus.req_type     = '0;
    req_bus.request_size = '0;
    req_bus.alignment    = '0;
    req_bus.address      = '0;
    rsp_bus.ready        = 1'b0;
    hold_off_request     = 1'b0;
    hold_left            = 0;
    stall_cycles         = 0;
    send_idle_pct        = 22;
    recv_idle_pct        = 82;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    run_directed();
    for (int ph = 0; ph < PHASES; ph++) run_phase(ph);
    wait_drained();
    // any stray response in this window is flagged by the checker
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (alloc_sb.mismatches == 0) begin
      $display("bump_allocator_slot_table test passed");
    end else begin
      $display("bump_allocator_slot_table test failed");
    end
    $finish;
  end

endmodule
